### rtl/osm_pkg.sv
// Shared types and constants for the order-statistic multiset.
// Request and response payloads, command codes and controller states.
// No dependencies.
package osm_pkg;

  localparam int unsigned VALUES_DEF     = 1024;
  localparam int unsigned COUNT_BITS_DEF = 20;
  localparam int unsigned MAXV_W         = 11;
  localparam logic [MAXV_W-1:0] MAX_VALUE_RST = 11'd1024;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [10:0] value;
    logic [19:0] rank;
  } osm_req_t;

  typedef struct packed {
    logic [10:0] result_value;
    logic        error;
    logic [19:0] total_count;
  } osm_rsp_t;

endpackage

### rtl/order_statistic_multiset_top.sv
// Order-statistic multiset top. A valid insert, remove or report strobes done after
// the root state fetches the root's left child and the walk then descends one tree level
// per cycle. The next command can transfer on the edge that ends the strobe.
// A rejected command, or report on an empty set, strobes the next cycle. After reset a
// clearing pass that zeroes every tree node holds busy high; no result stalls.
module order_statistic_multiset_top import osm_pkg::*; #(
  parameter int unsigned VALUES     = VALUES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  osm_req_t          req_i,
  output logic              done_o,
  output osm_rsp_t          rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [MAXV_W-1:0] cfg_data_i
);

  localparam int unsigned NODE_W = $clog2(VALUES) + 1;

  logic [MAXV_W-1:0]     max_value_q, max_value_d;
  logic                  mem_we, mem_re;
  logic [NODE_W-1:0]     mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign max_value_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : max_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MAX_VALUE_RST;
    end else begin
      max_value_q <= max_value_d;
    end
  end

  osm_ctrl #(
    .VALUES     (VALUES),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .max_value_i (max_value_q),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  osm_tree_mem #(
    .ADDR_W (NODE_W),
    .DATA_W (COUNT_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### rtl/osm_tree_mem.sv
// Count store: one write port, one read port, registered read data.
// Holds one counter per tree node. No package dependencies.
module osm_tree_mem #(
  parameter int unsigned ADDR_W = 11,
  parameter int unsigned DATA_W = 20
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/osm_ctrl.sv
// Command sequencer: validates commands, walks the count tree one level per cycle
// and updates the path counts on insert and remove. Depends on osm_pkg, drives osm_tree_mem.
module osm_ctrl import osm_pkg::*; #(
  parameter int unsigned VALUES     = VALUES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  localparam int unsigned NODE_W    = $clog2(VALUES) + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  osm_req_t              req_i,
  input  logic [MAXV_W-1:0]     max_value_i,
  output logic                  busy_o,
  output logic                  done_o,
  output osm_rsp_t              rsp_o,
  output logic                  mem_we_o,
  output logic [NODE_W-1:0]     mem_waddr_o,
  output logic [COUNT_BITS-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [NODE_W-1:0]     mem_raddr_o,
  input  logic [COUNT_BITS-1:0] mem_rdata_i
);

  localparam int unsigned VAL_W = $clog2(VALUES + 1);

  state_e                state_q, state_d;
  logic [NODE_W-1:0]     node_q, node_d;
  logic [VAL_W-1:0]      lo_q, lo_d, hi_q, hi_d, val_q, val_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, k_q, k_d, total_q, total_d;
  logic [1:0]            cmd_q, cmd_d;
  logic [NODE_W-1:0]     clr_q, clr_d;
  logic                  done_q, done_d;
  osm_rsp_t              rsp_q, rsp_d;

  // walk datapath
  logic [VAL_W:0]        sum;
  logic [VAL_W-1:0]      mid, clo, chi;
  logic                  go_left;
  logic [NODE_W-1:0]     child;
  logic [COUNT_BITS-1:0] cc, ck;
  logic [31:0]           lim32, val32, clo32, tot32;
  logic                  ins_bad, rem_bad;

  always_comb begin
    lim32   = (32'(max_value_i) > 32'(VALUES)) ? 32'(VALUES) : 32'(max_value_i);
    val32   = 32'(req_i.value);
    tot32   = 32'(total_q);
    ins_bad = (req_i.value == '0) || (val32 > lim32) || (total_q == '1);
    rem_bad = (req_i.rank == '0) || (32'(req_i.rank) > tot32);

    sum     = {1'b0, lo_q} + {1'b0, hi_q};
    mid     = sum[VAL_W:1];
    go_left = (cmd_q == CMD_INSERT) ? (val_q <= mid) : (mem_rdata_i >= k_q);
    child   = {node_q[NODE_W-2:0], ~go_left};
    cc      = go_left ? mem_rdata_i : cnt_q - mem_rdata_i;
    ck      = go_left ? k_q : k_q - mem_rdata_i;
    clo     = go_left ? lo_q : mid + VAL_W'(1);
    chi     = go_left ? mid : hi_q;
    clo32   = 32'(clo);
  end

  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    total_d     = total_q;
    cmd_d       = cmd_q;
    clr_d       = clr_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = child;
    mem_wdata_o = (cmd_q == CMD_INSERT) ? cc + COUNT_BITS'(1) : cc - COUNT_BITS'(1);
    mem_re_o    = 1'b0;
    mem_raddr_o = {child[NODE_W-2:0], 1'b0};

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + NODE_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_d  = req_i.cmd;
          node_d = NODE_W'(1);
          lo_d   = VAL_W'(1);
          hi_d   = VAL_W'(VALUES);
          cnt_d  = total_q;
          val_d  = val32[VAL_W-1:0];
          rsp_d.result_value = '0;
          rsp_d.error        = 1'b0;
          rsp_d.total_count  = tot32[19:0];
          case (req_i.cmd)
            CMD_INSERT: begin
              k_d = COUNT_BITS'(1);
              if (ins_bad) begin
                rsp_d.error = 1'b1;
                done_d      = 1'b1;
              end else begin
                state_d = ST_ROOT;
              end
            end
            CMD_REMOVE: begin
              k_d = COUNT_BITS'(32'(req_i.rank));
              if (rem_bad) begin
                rsp_d.error = 1'b1;
                done_d      = 1'b1;
              end else begin
                state_d = ST_ROOT;
              end
            end
            CMD_REPORT: begin
              k_d = COUNT_BITS'(1);
              if (total_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = ST_ROOT;
              end
            end
            default: begin
              rsp_d.error = 1'b1;
              done_d      = 1'b1;
            end
          endcase
        end
      end
      ST_ROOT: begin
        // root count lives in total_q; fetch the left child of the root
        mem_re_o    = 1'b1;
        mem_raddr_o = NODE_W'(2);
        case (cmd_q)
          CMD_INSERT: total_d = total_q + COUNT_BITS'(1);
          CMD_REMOVE: total_d = total_q - COUNT_BITS'(1);
          default:    total_d = total_q;
        endcase
        state_d = ST_WALK;
      end
      ST_WALK: begin
        // read data is the left-child count of node_q
        mem_we_o = (cmd_q != CMD_REPORT);
        if (clo >= chi) begin
          rsp_d.result_value = clo32[10:0];
          rsp_d.error        = 1'b0;
          rsp_d.total_count  = tot32[19:0];
          done_d             = 1'b1;
          state_d            = ST_IDLE;
        end else begin
          mem_re_o = 1'b1;
          node_d   = child;
          lo_d     = clo;
          hi_d     = chi;
          cnt_d    = cc;
          k_d      = ck;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    k_q    <= k_d;
    cmd_q  <= cmd_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
